/* sv/ipv6ar_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6ar_pkg
// Shared types, character codes and helpers of the IPv6 address recognizer.
// ----------------------------------------------------------------------------
package ipv6ar_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned GDIG_W   = 3;
    localparam int unsigned DVAL_W   = 9;
    localparam int unsigned DDIG_W   = 3;
    localparam int unsigned GCNT_W   = 4;
    localparam int unsigned OCT_W    = 2;
    localparam int unsigned PROD_W   = 12;

    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

    localparam logic [LEN_W-1:0]  LEN_MAX      = 6'd63;
    localparam logic [GCNT_W-1:0] GCNT_MAX     = 4'd15;
    localparam logic [GDIG_W-1:0] GDIG_SAT     = 3'd5;
    localparam logic [GDIG_W-1:0] GDIG_MAX     = 3'd4;
    localparam logic [DDIG_W-1:0] DDIG_MAX     = 3'd3;
    localparam logic [PROD_W-1:0] OCTET_MAX    = 12'd255;
    localparam logic [GCNT_W-1:0] GROUPS_FULL  = 4'd8;
    localparam logic [GCNT_W-1:0] GROUPS_SHORT = 4'd7;
    localparam logic [OCT_W-1:0]  OCT_LAST_SEP = 2'd2;
    localparam logic [LEN_W-1:0]  LEN_MIN_ACC  = 6'd2;

    typedef enum logic [5:0] {
        PH_IDLE           = 6'b000001,
        PH_LEAD_COLON     = 6'b000010,
        PH_GROUP          = 6'b000100,
        PH_AFTER_COLON    = 6'b001000,
        PH_OCT_NEED_DIGIT = 6'b010000,
        PH_OCT_DIGITS     = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_SCAN    = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_REJECT  = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [GDIG_W-1:0]   gdig;
        logic                dec_only;
        logic [DVAL_W-1:0]   dval;
        logic [DDIG_W-1:0]   ddig;
        logic [GCNT_W-1:0]   gcnt;
        logic                dcolon;
        logic [OCT_W-1:0]    oct_idx;
        logic [LEN_W-1:0]    len;
    } t_scan;

    localparam t_scan SCAN_CLEAR = '{
        phase:    PH_IDLE,
        gdig:     '0,
        dec_only: 1'b1,
        dval:     '0,
        ddig:     '0,
        gcnt:     '0,
        dcolon:   1'b0,
        oct_idx:  '0,
        len:      '0
    };

    function automatic logic f_is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic f_is_hex(input logic [CHAR_W-1:0] c);
        return f_is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // value * 10 + digit
    function automatic logic [PROD_W-1:0] f_dec_acc(input logic [DVAL_W-1:0] v,
                                                     input logic [CHAR_W-1:0] c);
        logic [PROD_W-1:0] w;
        logic [CHAR_W-1:0] d;
        w = PROD_W'(v);
        d = c - CH_0;
        return (w << 3) + (w << 1) + PROD_W'(d);
    endfunction

endpackage

/* sv/ipv6ar_in_if.sv */
// ----------------------------------------------------------------------------
// ipv6ar_in_if
// Character channel: one byte and an end marker per item.
// ----------------------------------------------------------------------------
interface ipv6ar_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

/* sv/ipv6ar_out_if.sv */
// ----------------------------------------------------------------------------
// ipv6ar_out_if
// Result channel: scan status and token length per item.
// ----------------------------------------------------------------------------
interface ipv6ar_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] token_length;

    modport source (output valid, output status, output token_length, input ready);
    modport sink   (input valid, input status, input token_length, output ready);
endinterface

/* sv/ipv6ar_step.sv */
// ----------------------------------------------------------------------------
// ipv6ar_step
// Next-state and status logic for one character of the address scan.
// ----------------------------------------------------------------------------
module ipv6ar_step (
    input  ipv6ar_pkg::t_scan              i_scan,
    input  logic [ipv6ar_pkg::CHAR_W-1:0]  i_char,
    input  logic                           i_eoi,
    output ipv6ar_pkg::t_scan              o_scan,
    output ipv6ar_pkg::t_status            o_status,
    output logic [ipv6ar_pkg::LEN_W-1:0]   o_length
);
    import ipv6ar_pkg::*;

    function automatic logic [LEN_W-1:0] f_count(input logic [LEN_W-1:0] l);
        return (l < LEN_MAX) ? l + 1'b1 : l;
    endfunction

    function automatic logic [GCNT_W-1:0] f_bump(input logic [GCNT_W-1:0] g);
        return (g < GCNT_MAX) ? g + 1'b1 : g;
    endfunction

    function automatic t_status f_verdict(input logic dc, input logic [GCNT_W-1:0] g);
        if (dc) begin
            return (g > GROUPS_SHORT) ? ST_REJECT : ST_ACCEPT;
        end
        return (g != GROUPS_FULL) ? ST_REJECT : ST_ACCEPT;
    endfunction

    function automatic t_scan f_new_group(input t_scan b);
        t_scan r;
        r          = b;
        r.gdig     = '0;
        r.dec_only = 1'b1;
        r.dval     = '0;
        r.ddig     = '0;
        return r;
    endfunction

    function automatic t_scan f_take_hex(input t_scan b, input logic [CHAR_W-1:0] c);
        t_scan             r;
        logic [PROD_W-1:0] v;
        logic [DDIG_W-1:0] dd;
        r  = b;
        v  = f_dec_acc(b.dval, c);
        dd = b.ddig + 1'b1;
        if (!f_is_dec(c)) begin
            r.dec_only = 1'b0;
        end else if (b.dec_only) begin
            r.ddig = dd;
            if ((dd > DDIG_MAX) || (v > OCTET_MAX)) begin
                r.dec_only = 1'b0;
            end else begin
                r.dval = v[DVAL_W-1:0];
            end
        end
        if (b.gdig < GDIG_SAT) begin
            r.gdig = b.gdig + 1'b1;
        end
        r.len = f_count(b.len);
        return r;
    endfunction

    logic [CHAR_W-1:0] c;
    logic              c_dec;
    logic              c_hex;
    logic              c_colon;
    logic              c_dot;
    logic [PROD_W-1:0] oct_v;
    logic [DDIG_W-1:0] oct_dd;
    t_scan             n_scan;
    t_status           st;

    // end of input reads as a NUL terminator
    assign c       = i_eoi ? '0 : i_char;
    assign c_dec   = f_is_dec(c);
    assign c_hex   = f_is_hex(c);
    assign c_colon = (c == CH_COLON);
    assign c_dot   = (c == CH_DOT);
    assign oct_v   = f_dec_acc(i_scan.dval, c);
    assign oct_dd  = i_scan.ddig + 1'b1;

    always_comb begin
        n_scan = i_scan;
        st     = ST_SCAN;
        case (i_scan.phase)
            PH_IDLE: begin
                if (c_colon) begin
                    n_scan.len   = f_count(i_scan.len);
                    n_scan.phase = PH_LEAD_COLON;
                end else if (c_hex) begin
                    n_scan       = f_take_hex(f_new_group(i_scan), c);
                    n_scan.phase = PH_GROUP;
                end else begin
                    st = ST_NOMATCH;
                end
            end
            PH_LEAD_COLON: begin
                if (c_colon) begin
                    n_scan        = f_new_group(i_scan);
                    n_scan.len    = f_count(i_scan.len);
                    n_scan.dcolon = 1'b1;
                    n_scan.phase  = PH_GROUP;
                end else begin
                    st = ST_REJECT;
                end
            end
            PH_GROUP: begin
                if (c_hex) begin
                    n_scan = f_take_hex(i_scan, c);
                end else if (i_scan.gdig == '0) begin
                    st = f_verdict(i_scan.dcolon, i_scan.gcnt);
                end else if (i_scan.gdig > GDIG_MAX) begin
                    st = ST_REJECT;
                end else begin
                    n_scan.gcnt = f_bump(i_scan.gcnt);
                    if (c_dot) begin
                        if (!i_scan.dec_only || (i_scan.ddig == '0)) begin
                            st = ST_REJECT;
                        end else begin
                            n_scan.len     = f_count(i_scan.len);
                            n_scan.oct_idx = '0;
                            n_scan.phase   = PH_OCT_NEED_DIGIT;
                        end
                    end else if (c_colon) begin
                        n_scan.len   = f_count(i_scan.len);
                        n_scan.phase = PH_AFTER_COLON;
                    end else begin
                        st = f_verdict(i_scan.dcolon, n_scan.gcnt);
                    end
                end
            end
            PH_AFTER_COLON: begin
                if (c_colon) begin
                    if (i_scan.dcolon) begin
                        st = ST_REJECT;
                    end else begin
                        n_scan        = f_new_group(i_scan);
                        n_scan.dcolon = 1'b1;
                        n_scan.len    = f_count(i_scan.len);
                        n_scan.phase  = PH_GROUP;
                    end
                end else if (c_hex) begin
                    n_scan       = f_take_hex(f_new_group(i_scan), c);
                    n_scan.phase = PH_GROUP;
                end else begin
                    st = ST_REJECT;
                end
            end
            PH_OCT_NEED_DIGIT: begin
                if (c_dec) begin
                    n_scan.dval  = DVAL_W'(c - CH_0);
                    n_scan.ddig  = DDIG_W'(1);
                    n_scan.len   = f_count(i_scan.len);
                    n_scan.phase = PH_OCT_DIGITS;
                end else begin
                    st = ST_REJECT;
                end
            end
            PH_OCT_DIGITS: begin
                if (c_dec) begin
                    n_scan.ddig = oct_dd;
                    if ((oct_dd > DDIG_MAX) || (oct_v > OCTET_MAX)) begin
                        st = ST_REJECT;
                    end else begin
                        n_scan.dval = oct_v[DVAL_W-1:0];
                        n_scan.len  = f_count(i_scan.len);
                    end
                end else if (i_scan.oct_idx < OCT_LAST_SEP) begin
                    if (c_dot) begin
                        n_scan.oct_idx = i_scan.oct_idx + 1'b1;
                        n_scan.len     = f_count(i_scan.len);
                        n_scan.phase   = PH_OCT_NEED_DIGIT;
                    end else begin
                        st = ST_REJECT;
                    end
                end else begin
                    // the dotted tail closes its second group here
                    n_scan.gcnt = f_bump(i_scan.gcnt);
                    st          = f_verdict(i_scan.dcolon, n_scan.gcnt);
                end
            end
            default: begin
                n_scan = SCAN_CLEAR;
            end
        endcase
    end

    assign o_status = st;
    assign o_length = (st == ST_ACCEPT) ? n_scan.len : '0;
    assign o_scan   = (st != ST_SCAN) ? SCAN_CLEAR : n_scan;

endmodule

/* sv/ipv6_address_recognizer_unit.sv */
// ----------------------------------------------------------------------------
// ipv6_address_recognizer_unit
// Recognizes textual IPv6 addresses, one character per item.
// ----------------------------------------------------------------------------
//  channel   dir  payload                       handshake
//  i_in      in   char_code[7:0], end_of_input  valid / ready
//  o_out     out  status[1:0], token_length[5:0] valid / ready
//
//  one result item per input item; one item per cycle unless o_out stalls:
//  input register, step logic, result register
//  i_rst_n (synchronous, active low) returns the scan to idle and empties both
//  registers; the result register is freed in the cycle it is taken, so a
//  stall on o_out holds the input register and then drops i_in.ready
// ----------------------------------------------------------------------------
module ipv6_address_recognizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipv6ar_in_if.sink  i_in,
    ipv6ar_out_if.source o_out
);
    import ipv6ar_pkg::*;

    logic                r_stg_valid;
    logic [CHAR_W-1:0]   r_stg_char;
    logic                r_stg_eoi;
    t_scan               r_scan;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [LEN_W-1:0]    r_out_len;

    t_scan               n_scan;
    t_status             n_status;
    logic [LEN_W-1:0]    n_len;
    logic                advance;
    logic                take_in;

    ipv6ar_step u_step (
        .i_scan   (r_scan),
        .i_char   (r_stg_char),
        .i_eoi    (r_stg_eoi),
        .o_scan   (n_scan),
        .o_status (n_status),
        .o_length (n_len)
    );

    assign advance     = r_stg_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_stg_valid || advance;
    assign take_in     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (take_in) begin
            r_stg_valid <= 1'b1;
        end else if (advance) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_stg_char <= i_in.char_code;
            r_stg_eoi  <= i_in.end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_CLEAR;
        end else if (advance) begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_status;
            r_out_len    <= n_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.token_length = r_out_len;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_scan.phase))
        else $error("scan phase lost its one-hot code");

    a_verdict_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_status != ST_SCAN)) |=> (r_scan == SCAN_CLEAR))
        else $error("scan not restarted after a verdict");

    a_len_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_ACCEPT)) |-> (r_out_len == '0))
        else $error("token length on a non-accept item");

    a_accept_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_ACCEPT)) |-> (r_out_len >= LEN_MIN_ACC))
        else $error("accepted address shorter than two characters");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_valid && !advance) |=> (r_stg_valid && $stable(r_stg_char)
                                       && $stable(r_stg_eoi)))
        else $error("held input item overwritten");

endmodule
